// ===== design/mbe_pkg.sv =====
// shared types, constants and helpers for the mandelbrot escape-time block
package mbe_pkg;

   localparam int FRAC_BITS   = 28;
   localparam int Z_WIDTH     = FRAC_BITS + 8;
   localparam int MUL_WIDTH   = FRAC_BITS + 2;
   localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
   localparam int SQ_WIDTH    = MUL_WIDTH + 1;
   localparam int CROSS_WIDTH = PROD_WIDTH - FRAC_BITS + 1;
   localparam int COORD_WIDTH = 14;
   localparam int STEP_WIDTH  = 29;
   localparam int COUNT_WIDTH = 8;
   localparam int TOTAL_WIDTH = 48;

   localparam logic [COUNT_WIDTH-1:0] MAX_ITERATIONS = COUNT_WIDTH'(255);
   localparam logic [STEP_WIDTH-1:0]  STEP_RESET     = STEP_WIDTH'(65536);

   localparam logic signed [Z_WIDTH-1:0] Z_LIMIT     = Z_WIDTH'(64'd1 << (FRAC_BITS + 1));
   localparam logic [Z_WIDTH-1:0]        C_RE_OFFSET = Z_WIDTH'(64'd2 << FRAC_BITS);
   localparam logic [Z_WIDTH-1:0]        C_IM_OFFSET = Z_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic [SQ_WIDTH:0]         MAG_LIMIT   = (SQ_WIDTH + 1)'(64'd4 << FRAC_BITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CR,
      ST_CI,
      ST_RR,
      ST_II,
      ST_RI,
      ST_UPD,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      OP_COL,
      OP_ROW,
      OP_RR,
      OP_II,
      OP_RI,
      OP_NX
   } op_sel_type;

   typedef struct packed {
      op_sel_type op_sel;
      logic       init;
      logic       ld_cr;
      logic       ld_ci;
      logic       ld_sqr;
      logic       step_ri;
      logic       upd;
      logic       finish;
   } ctrl_type;

   typedef struct packed {
      logic first;
      logic mag_esc;
      logic count_full;
      logic range_esc;
   } status_type;

   // component of magnitude 2 or more escapes at once
   function automatic logic z_escaped(input logic signed [Z_WIDTH-1:0] z);
      z_escaped = (z >= Z_LIMIT) || (z <= -Z_LIMIT);
   endfunction

endpackage

// ===== design/mbe_mul.sv =====
// shared signed multiplier with registered product
module mbe_mul (
   input  logic                                 clock,
   input  logic signed [mbe_pkg::MUL_WIDTH-1:0]  op_a,
   input  logic signed [mbe_pkg::MUL_WIDTH-1:0]  op_b,
   output logic signed [mbe_pkg::PROD_WIDTH-1:0] prod_ff
);
   import mbe_pkg::*;

   logic signed [PROD_WIDTH-1:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== design/mbe_seq.sv =====
// sequencer that steps the shared multiplier through one pixel
module mbe_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  mbe_pkg::status_type   status,
   output mbe_pkg::ctrl_type     ctrl,
   output logic                  busy
);
   import mbe_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      ctrl         = '0;
      ctrl.op_sel  = OP_COL;
      busy         = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctrl.init = 1'b1;
               state_in  = ST_CR;
            end
         end
         ST_CR: begin
            ctrl.op_sel = OP_COL;
            state_in    = ST_CI;
         end
         ST_CI: begin
            ctrl.op_sel = OP_ROW;
            ctrl.ld_cr  = 1'b1;
            state_in    = ST_RR;
         end
         ST_RR: begin
            ctrl.op_sel = OP_RR;
            ctrl.ld_ci  = 1'b1;
            state_in    = ST_II;
         end
         ST_II: begin
            ctrl.op_sel = OP_II;
            ctrl.ld_sqr = 1'b1;
            state_in    = ST_RI;
         end
         ST_RI: begin
            ctrl.op_sel  = OP_RI;
            ctrl.step_ri = 1'b1;
            if (!status.first && (status.mag_esc || status.count_full)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPD;
            end
         end
         ST_UPD: begin
            ctrl.op_sel = OP_NX;
            ctrl.upd    = 1'b1;
            if (status.range_esc) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_II;
            end
         end
         ST_DONE: begin
            ctrl.finish = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/mandelbrot_escape_iteration.sv =====
// top level of the mandelbrot escape-time engine: datapath, result and csr ports
//
// One pixel at a time. A word is taken when start is high and busy is low; the
// pixel maps to c = (col*step - 2, row*step - 1) and z = z^2 + c is iterated from
// zero in signed 36-bit fixed point with 28 fraction bits, each product floored.
// All products go through one 30x30 signed multiplier with a registered output,
// so an iteration is three products in turn (zi^2, zr*zi, then the new zr^2 while
// z is updated); the iteration count stops at the cap of 255. The result is on the
// rsp_ ports for exactly one cycle with rsp_valid high and cannot be held off;
// the next pixel may be started in that same cycle. rsp_running_total is the
// tile total including this pixel and clears after a pixel with last set.
// csr_step_size is taken only while the block is idle (csr_ready = !busy).
module mandelbrot_escape_iteration (
   input  logic                                 clock,
   input  logic                                 reset,
   // pixel request
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mbe_pkg::COORD_WIDTH-1:0]      req_pixel_col,
   input  logic [mbe_pkg::COORD_WIDTH-1:0]      req_pixel_row,
   input  logic                                 req_last_pixel,
   // result
   output logic                                 rsp_valid,
   output logic [mbe_pkg::COUNT_WIDTH-1:0]      rsp_iter_count,
   output logic [mbe_pkg::TOTAL_WIDTH-1:0]      rsp_running_total,
   output logic                                 rsp_last,
   // step size register
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mbe_pkg::STEP_WIDTH-1:0]       csr_step_size
);
   import mbe_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   // pixel and configuration registers
   logic [STEP_WIDTH-1:0]  step_ff;
   logic [COORD_WIDTH-1:0] col_ff;
   logic [COORD_WIDTH-1:0] row_ff;
   logic                   last_ff;

   // iteration state
   logic signed [Z_WIDTH-1:0] cr_ff,   cr_in;
   logic signed [Z_WIDTH-1:0] ci_ff,   ci_in;
   logic signed [Z_WIDTH-1:0] zr_ff,   zr_in;
   logic signed [Z_WIDTH-1:0] zi_ff,   zi_in;
   logic signed [Z_WIDTH-1:0] zr_nx_ff, zr_nx_in;
   logic [SQ_WIDTH-1:0]       sqr_ff,  sqr_in;
   logic [COUNT_WIDTH-1:0]    count_ff, count_in;
   logic                      first_ff, first_in;

   // tile total and result registers
   logic [TOTAL_WIDTH-1:0] sum_ff,   sum_in;
   logic [TOTAL_WIDTH-1:0] total_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [COUNT_WIDTH-1:0] rsp_count_ff;
   logic [TOTAL_WIDTH-1:0] rsp_total_ff;
   logic                   rsp_last_ff;

   // multiplier and derived terms
   logic signed [MUL_WIDTH-1:0]  op_a;
   logic signed [MUL_WIDTH-1:0]  op_b;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic [SQ_WIDTH-1:0]          sq_cur;
   logic [SQ_WIDTH:0]            mag;
   logic signed [Z_WIDTH-1:0]    cross_ext;
   logic signed [Z_WIDTH-1:0]    zi_new;
   logic [COUNT_WIDTH-1:0]       count_inc;

   mbe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .ctrl   (ctrl),
      .busy   (busy)
   );

   mbe_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod_ff)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (ctrl.op_sel)
         OP_COL: begin
            op_a = $signed({{(MUL_WIDTH-COORD_WIDTH){1'b0}}, col_ff});
            op_b = $signed({{(MUL_WIDTH-STEP_WIDTH){1'b0}}, step_ff});
         end
         OP_ROW: begin
            op_a = $signed({{(MUL_WIDTH-COORD_WIDTH){1'b0}}, row_ff});
            op_b = $signed({{(MUL_WIDTH-STEP_WIDTH){1'b0}}, step_ff});
         end
         OP_RR: begin
            op_a = zr_ff[MUL_WIDTH-1:0];
            op_b = zr_ff[MUL_WIDTH-1:0];
         end
         OP_II: begin
            op_a = zi_ff[MUL_WIDTH-1:0];
            op_b = zi_ff[MUL_WIDTH-1:0];
         end
         OP_RI: begin
            op_a = zr_ff[MUL_WIDTH-1:0];
            op_b = zi_ff[MUL_WIDTH-1:0];
         end
         OP_NX: begin
            // garbage when zr_nx is out of range, but then the pixel ends
            op_a = zr_nx_ff[MUL_WIDTH-1:0];
            op_b = zr_nx_ff[MUL_WIDTH-1:0];
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // squares are non-negative and below 2^(FRAC_BITS+2) once z is in range,
   // so the floored square is just a slice of the product
   assign sq_cur = prod_ff[FRAC_BITS+SQ_WIDTH-1:FRAC_BITS];
   assign mag    = {1'b0, sqr_ff} + {1'b0, sq_cur};

   // 2*zr*zi is the product floored one bit less
   assign cross_ext = {{(Z_WIDTH-CROSS_WIDTH){prod_ff[PROD_WIDTH-1]}},
                       prod_ff[PROD_WIDTH-1:FRAC_BITS-1]};
   assign zi_new    = cross_ext + ci_ff;

   assign count_inc = count_ff + COUNT_WIDTH'(1);

   always_comb begin
      status.first      = first_ff;
      status.mag_esc    = (mag >= MAG_LIMIT);
      status.count_full = (count_inc == MAX_ITERATIONS);
      status.range_esc  = z_escaped(zr_nx_ff) || z_escaped(zi_new);
   end

   // iteration datapath
   always_comb begin
      cr_in    = cr_ff;
      ci_in    = ci_ff;
      zr_in    = zr_ff;
      zi_in    = zi_ff;
      zr_nx_in = zr_nx_ff;
      sqr_in   = sqr_ff;
      count_in = count_ff;
      first_in = first_ff;
      if (ctrl.init) begin
         zr_in    = '0;
         zi_in    = '0;
         count_in = '0;
         first_in = 1'b1;
      end
      if (ctrl.ld_cr) begin
         cr_in = prod_ff[Z_WIDTH-1:0] - C_RE_OFFSET;
      end
      if (ctrl.ld_ci) begin
         ci_in = prod_ff[Z_WIDTH-1:0] - C_IM_OFFSET;
      end
      if (ctrl.ld_sqr) begin
         sqr_in = sq_cur;
      end
      if (ctrl.step_ri) begin
         // real part of the next z from the squares of the current one
         zr_nx_in = $signed({{(Z_WIDTH-SQ_WIDTH){1'b0}}, sqr_ff})
                  - $signed({{(Z_WIDTH-SQ_WIDTH){1'b0}}, sq_cur}) + cr_ff;
         // magnitude of the current z decides whether the last step counts
         if (!first_ff && !status.mag_esc) begin
            count_in = count_inc;
         end
      end
      if (ctrl.upd) begin
         zr_in    = zr_nx_ff;
         zi_in    = zi_new;
         first_in = 1'b0;
      end
   end

   // tile total and result word
   assign total_in = sum_ff + {{(TOTAL_WIDTH-COUNT_WIDTH){1'b0}}, count_ff};

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = 1'b0;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
         sum_in       = last_ff ? '0 : total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_RESET;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         first_ff     <= 1'b1;
      end else begin
         if (csr_valid && csr_ready) begin
            step_ff <= csr_step_size;
         end
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctrl.init) begin
         col_ff  <= req_pixel_col;
         row_ff  <= req_pixel_row;
         last_ff <= req_last_pixel;
      end
      if (ctrl.finish) begin
         rsp_count_ff <= count_ff;
         rsp_total_ff <= total_in;
         rsp_last_ff  <= last_ff;
      end
      cr_ff    <= cr_in;
      ci_ff    <= ci_in;
      zr_ff    <= zr_in;
      zi_ff    <= zi_in;
      zr_nx_ff <= zr_nx_in;
      sqr_ff   <= sqr_in;
   end

   assign csr_ready         = !busy;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_iter_count    = rsp_count_ff;
   assign rsp_running_total = rsp_total_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ===== tb/tb_mandelbrot_escape_iteration.sv =====
// testbench for the mandelbrot escape-time engine: pixels driven, results checked by a predictor
`timescale 1ns / 1ps

module tb_mandelbrot_escape_iteration;
   import mbe_pkg::*;

   localparam int RANDOM_PIXELS  = 1830;
   localparam int QUIET_TAIL     = 200;   // last pixels go out back to back
   localparam int WATCHDOG_LIMIT = 4000;  // outlasts the slowest pixel, one that runs to the cap
   localparam int SETTLE_CYCLES  = 40;
   localparam int COORD_MAX      = (1 << COORD_WIDTH) - 1;
   localparam int STEP_ONE       = 1 << FRAC_BITS;  // one pixel per unit of c
   localparam logic [STEP_WIDTH-1:0] STEP_MAX = '1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] iter_count;
      logic [TOTAL_WIDTH-1:0] running_total;
      logic                   last;
   } escape_result_type;

   // escape-count predictor plus the queue of words still owed by the engine
   class escape_scoreboard;
      logic [STEP_WIDTH-1:0]  step_size;
      logic [TOTAL_WIDTH-1:0] tile_total;
      escape_result_type      expected_q[$];
      int                     mismatches;

      function new();
         step_size  = STEP_RESET;
         tile_total = '0;
         mismatches = 0;
      endfunction

      function void set_step(input logic [STEP_WIDTH-1:0] value);
         step_size = value;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // keep the low Z_WIDTH bits as a two's complement value
      function longint to_z(input longint v);
         logic signed [Z_WIDTH-1:0] narrow;
         narrow = v[Z_WIDTH-1:0];
         return longint'(narrow);
      endfunction

      function void note_pixel(input logic [COORD_WIDTH-1:0] col, row, input logic last);
         longint            c_re, c_im, z_re, z_im, sq_re, sq_im, z_bound, four;
         int                n;
         escape_result_type exp_word;
         z_bound = longint'(1) << (FRAC_BITS + 1);
         four    = longint'(4) << FRAC_BITS;
         c_re = to_z(longint'(col) * longint'(step_size) - (longint'(2) << FRAC_BITS));
         c_im = to_z(longint'(row) * longint'(step_size) - (longint'(1) << FRAC_BITS));
         z_re = 0;
         z_im = 0;
         // |z| < 2 holds before every square, so the products fit in 64 bits
         for (n = 0; n < int'(MAX_ITERATIONS); n++) begin
            sq_re = (z_re * z_re) >>> FRAC_BITS;
            sq_im = (z_im * z_im) >>> FRAC_BITS;
            z_im  = to_z(((z_re * z_im) >>> (FRAC_BITS - 1)) + c_im);
            z_re  = to_z(sq_re - sq_im + c_re);
            if (z_re >= z_bound || z_re <= -z_bound || z_im >= z_bound || z_im <= -z_bound)
               break;
            if (((z_re * z_re) >>> FRAC_BITS) + ((z_im * z_im) >>> FRAC_BITS) >= four)
               break;
         end
         tile_total             = tile_total + TOTAL_WIDTH'(n);
         exp_word.iter_count    = COUNT_WIDTH'(n);
         exp_word.running_total = tile_total;
         exp_word.last          = last;
         expected_q.push_back(exp_word);
         if (last)
            tile_total = '0;
      endfunction

      function void check_result(input logic [COUNT_WIDTH-1:0] iter_count,
                                 input logic [TOTAL_WIDTH-1:0] running_total,
                                 input logic                   last);
         escape_result_type exp_word;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result word, count %0d total %0d last %0b",
                     $time, iter_count, running_total, last);
            mismatches++;
            return;
         end
         exp_word = expected_q.pop_front();
         if (iter_count !== exp_word.iter_count) begin
            $display("%0t: iter_count expected %0d, got %0d",
                     $time, exp_word.iter_count, iter_count);
            mismatches++;
         end
         if (running_total !== exp_word.running_total) begin
            $display("%0t: running_total expected %0d, got %0d",
                     $time, exp_word.running_total, running_total);
            mismatches++;
         end
         if (last !== exp_word.last) begin
            $display("%0t: last expected %0b, got %0b", $time, exp_word.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [COORD_WIDTH-1:0] req_pixel_col;
   logic [COORD_WIDTH-1:0] req_pixel_row;
   logic                   req_last_pixel;
   logic                   rsp_valid;
   logic [COUNT_WIDTH-1:0] rsp_iter_count;
   logic [TOTAL_WIDTH-1:0] rsp_running_total;
   logic                   rsp_last;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [STEP_WIDTH-1:0]  csr_step_size;

   escape_scoreboard sb;
   int               idle_cycles = 0;

   mandelbrot_escape_iteration DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_pixel_col     (req_pixel_col),
      .req_pixel_row     (req_pixel_row),
      .req_last_pixel    (req_last_pixel),
      .rsp_valid         (rsp_valid),
      .rsp_iter_count    (rsp_iter_count),
      .rsp_running_total (rsp_running_total),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_step_size     (csr_step_size)
   );

   always #5 clock = ~clock;

   // present one pixel word from the falling edge and hold it until the engine takes it;
   // start stays high afterwards so a following call can chain without a gap
   task automatic send_pixel(input logic [COORD_WIDTH-1:0] col, row, input logic last);
      @(negedge clock);
      start          <= 1'b1;
      req_pixel_col  <= col;
      req_pixel_row  <= row;
      req_last_pixel <= last;
      do @(posedge clock); while (busy);
      sb.note_pixel(col, row, last);
   endtask

   // drop start for a burst of idle cycles
   task automatic pause_requests(input int cycles);
      @(negedge clock);
      start <= 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending and wait until every owed result word has come back
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // step register write, only issued with the engine drained
   task automatic write_step(input logic [STEP_WIDTH-1:0] value);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_step_size <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_step(value);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // result side: no backpressure, so every strobe is checked as it goes by;
   // the idle counter feeds the watchdog and is cleared by any handshake
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_valid)
            sb.check_result(rsp_iter_count, rsp_running_total, rsp_last);
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
      end
   end

   // watchdog: a hung engine ends the run
   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int                     random_sent;
      int                     phase_left;
      int                     span;
      bit                     idling;
      logic [STEP_WIDTH-1:0]  step;
      logic [COORD_WIDTH-1:0] col;
      logic [COORD_WIDTH-1:0] row;
      logic                   last;

      sb             = new();
      reset          = 1'b1;
      start          = 1'b0;
      req_pixel_col  = '0;
      req_pixel_row  = '0;
      req_last_pixel = 1'b0;
      csr_valid      = 1'b0;
      csr_step_size  = '0;
      random_sent    = 0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // directed: reset step of 2^-12, corners, origin inside the set, tile ends
      send_pixel(0, 0, 1'b0);
      send_pixel(8192, 4096, 1'b0);             // c = 0, runs to the cap
      send_pixel(COORD_MAX, COORD_MAX, 1'b0);
      send_pixel(COORD_MAX, 0, 1'b0);
      send_pixel(0, COORD_MAX, 1'b1);           // tile end, total clears after
      send_pixel(2048, 4096, 1'b0);             // c = -1.5 on the real axis
      send_pixel(6144, 8192, 1'b1);
      drain_results();

      // step of zero puts every pixel at c = (-2, -1)
      write_step('0);
      send_pixel(0, 0, 1'b0);
      send_pixel(COORD_MAX, COORD_MAX, 1'b1);
      drain_results();

      // unit step: pixel (0, 1) lands z on magnitude 2 at once, and c wraps for large indexes
      write_step(STEP_WIDTH'(STEP_ONE));
      send_pixel(0, 1, 1'b0);
      send_pixel(1, 1, 1'b0);
      send_pixel(2, 1, 1'b0);
      send_pixel(COORD_MAX, 0, 1'b0);
      send_pixel(COORD_MAX, COORD_MAX, 1'b1);
      drain_results();

      // smallest nonzero step
      write_step(STEP_WIDTH'(1));
      send_pixel(COORD_MAX, COORD_MAX, 1'b0);
      send_pixel(0, 0, 1'b1);
      drain_results();

      // all step bits set
      write_step(STEP_MAX);
      send_pixel(1, 2, 1'b0);
      send_pixel(COORD_MAX, COORD_MAX, 1'b1);
      drain_results();

      // random phases, each with its own step; most pixels fall in the window
      // [-2, 1] x [-1, 1] so that long orbits and the cap are common
      while (random_sent < RANDOM_PIXELS) begin
         span = $urandom_range(64, 8192);
         case ($urandom_range(0, 9))
            0: begin
               step = STEP_WIDTH'(1);
               span = 5461;
            end
            1: begin
               step = STEP_WIDTH'(STEP_ONE);
               span = 5461;
            end
            2: begin
               step = STEP_WIDTH'($urandom_range(1, int'(STEP_MAX)));
               span = 5461;
            end
            default: step = STEP_WIDTH'((STEP_ONE + span / 2) / span);
         endcase
         write_step(step);
         phase_left = $urandom_range(40, 200);
         idling     = ($urandom_range(0, 3) != 0);
         // once in the tail the phase runs to the end, so no step change opens a gap
         while ((phase_left > 0 || random_sent >= RANDOM_PIXELS - QUIET_TAIL)
                && random_sent < RANDOM_PIXELS) begin
            if ($urandom_range(0, 4) == 0) begin
               col = COORD_WIDTH'($urandom());
               row = COORD_WIDTH'($urandom());
            end else begin
               col = COORD_WIDTH'($urandom_range(0, (3 * span > COORD_MAX) ? COORD_MAX : 3 * span));
               row = COORD_WIDTH'($urandom_range(0, (2 * span > COORD_MAX) ? COORD_MAX : 2 * span));
            end
            last = ($urandom_range(0, 15) == 0);
            send_pixel(col, row, last);
            random_sent++;
            phase_left--;
            if (random_sent >= RANDOM_PIXELS - QUIET_TAIL)
               idling = 1'b0;
            if (idling && $urandom_range(0, 3) == 0)
               pause_requests($urandom_range(1, 15));
            else if (idling && $urandom_range(0, 99) == 0)
               drain_results();                 // hold back until the engine has caught up
         end
         drain_results();
      end

      // catch any stray word after the last expected one
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ===== files.f =====
design/mbe_pkg.sv
design/mbe_mul.sv
design/mbe_seq.sv
design/mandelbrot_escape_iteration.sv
tb/tb_mandelbrot_escape_iteration.sv
